[rtl/fhd_pkg.sv]
// Shared types and constants for the frame header deframer.
package fhd_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int COUNT_W      = 4;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 32;

    // Byte positions inside the header at which each field starts.
    localparam logic [COUNT_W-1:0] VERSION_START = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] TYPE_START    = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] LENGTH_START  = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] LAST_HEADER   = COUNT_W'(HEADER_BYTES - 1);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MAGIC   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BODY_LENGTH  = CFG_INDEX_W'(2);

    localparam logic [31:0] MAX_BODY_LENGTH_RESET = 32'd65536;

    // Result kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_BODY   = 1'b1;

    // Header status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_ID   = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [15:0] expected_version;
        logic [31:0] max_body_length;
    } cfg_t;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  status;
        logic [15:0] frame_type;
        logic [31:0] body_length;
        logic [7:0]  body_byte;
        logic        last;
    } result_t;

endpackage

[rtl/fhd_parser.sv]
// Header gathering, header checks and body byte counting for one beat.
module fhd_parser
    import fhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  cfg_t        cfg,
    output logic        res_valid,
    output result_t     res
);

    logic               in_body_reg, in_body_next;
    logic [COUNT_W-1:0] header_count_reg, header_count_next;
    logic [31:0]        magic_shift_reg, magic_shift_next;
    logic [15:0]        version_shift_reg, version_shift_next;
    logic [15:0]        type_shift_reg, type_shift_next;
    logic [31:0]        length_shift_reg, length_shift_next;
    logic [31:0]        body_remaining_reg, body_remaining_next;

    logic               body_last;
    logic               header_done;
    logic [1:0]         status;
    logic               header_last;

    always_comb
    begin
        magic_shift_next   = magic_shift_reg;
        version_shift_next = version_shift_reg;
        type_shift_next    = type_shift_reg;
        length_shift_next  = length_shift_reg;
        if (!in_body_reg)
        begin
            if (header_count_reg < VERSION_START)
            begin
                magic_shift_next = {magic_shift_reg[23:0], in_byte};
            end
            else if (header_count_reg < TYPE_START)
            begin
                version_shift_next = {version_shift_reg[7:0], in_byte};
            end
            else if (header_count_reg < LENGTH_START)
            begin
                type_shift_next = {type_shift_reg[7:0], in_byte};
            end
            else
            begin
                length_shift_next = {length_shift_reg[23:0], in_byte};
            end
        end
    end

    assign body_last   = (body_remaining_reg <= 32'd1);
    assign header_done = (header_count_reg >= LAST_HEADER);

    // The identity check wins over the length check.
    always_comb
    begin
        if (magic_shift_next != cfg.expected_magic
            || version_shift_next != cfg.expected_version)
        begin
            status = STATUS_BAD_ID;
        end
        else if (length_shift_next > cfg.max_body_length)
        begin
            status = STATUS_TOO_LONG;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    assign header_last = (status != STATUS_OK) || (length_shift_next == 32'd0);

    always_comb
    begin
        in_body_next        = in_body_reg;
        header_count_next   = header_count_reg;
        body_remaining_next = body_remaining_reg;
        if (in_body_reg)
        begin
            if (body_last)
            begin
                in_body_next        = 1'b0;
                body_remaining_next = 32'd0;
                header_count_next   = '0;
            end
            else
            begin
                body_remaining_next = body_remaining_reg - 32'd1;
            end
        end
        else if (!header_done)
        begin
            header_count_next = header_count_reg + COUNT_W'(1);
        end
        else
        begin
            header_count_next = '0;
            if (!header_last)
            begin
                in_body_next        = 1'b1;
                body_remaining_next = length_shift_next;
            end
        end
    end

    always_comb
    begin
        res.frame_type  = type_shift_next;
        res.body_length = length_shift_next;
        if (in_body_reg)
        begin
            res.result_kind = KIND_BODY;
            res.status      = STATUS_OK;
            res.body_byte   = in_byte;
            res.last        = body_last;
        end
        else
        begin
            res.result_kind = KIND_HEADER;
            res.status      = status;
            res.body_byte   = 8'd0;
            res.last        = header_last;
        end
        res_valid = accept && (in_body_reg || header_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg        <= 1'b0;
            header_count_reg   <= '0;
            magic_shift_reg    <= '0;
            version_shift_reg  <= '0;
            type_shift_reg     <= '0;
            length_shift_reg   <= '0;
            body_remaining_reg <= '0;
        end
        else if (accept)
        begin
            in_body_reg        <= in_body_next;
            header_count_reg   <= header_count_next;
            magic_shift_reg    <= magic_shift_next;
            version_shift_reg  <= version_shift_next;
            type_shift_reg     <= type_shift_next;
            length_shift_reg   <= length_shift_next;
            body_remaining_reg <= body_remaining_next;
        end
    end

endmodule

[rtl/fhd_out_buf.sv]
// Output register with one skid entry for result beats.
module fhd_out_buf
    import fhd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/frame_header_deframer.sv]
// Top level of the length-prefixed frame header deframer.
//
// The block takes one raw byte per beat and accepts a new byte in every cycle
// as long as its output stage has room. It collects a 12-byte big-endian
// header (32-bit magic, 16-bit version, 16-bit frame type, 32-bit body
// length); header bytes give no result until the last one, which gives a
// header verdict. A wrong magic or version gives status 1, otherwise a length
// above max_body_length gives status 2, and either failure ends the frame
// with last set; the next byte then starts a new header. On success each body
// byte comes out as one result beat, the final one marked last, and a zero
// length header is itself marked last. The result of an accepted byte is
// registered in the output stage, whose register is backed by one skid entry,
// so input ready drops only when a result is already waiting behind a stalled
// output; the rate is one byte per cycle while input ready is high. The user
// must write configuration through cfg_write, cfg_index and cfg_data while
// the stream is idle; the block does not enforce it. Other indexes are ignored.
module frame_header_deframer
    import fhd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   result_kind,
    output logic [1:0]             status,
    output logic [15:0]            frame_type,
    output logic [31:0]            body_length,
    output logic [7:0]             body_byte,
    output logic                   last
);

    cfg_t    cfg_reg;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;

    // Configuration registers. Each write to a listed index lands in the one
    // register it selects; the version register keeps only its low sixteen bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_magic   <= '0;
            cfg_reg.expected_version <= '0;
            cfg_reg.max_body_length  <= MAX_BODY_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EXPECTED_MAGIC:   cfg_reg.expected_magic   <= cfg_data;
                CFG_EXPECTED_VERSION: cfg_reg.expected_version <= cfg_data[15:0];
                CFG_MAX_BODY_LENGTH:  cfg_reg.max_body_length  <= cfg_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A byte is taken whenever one is offered and the skid entry is free.
    assign accept = in_valid && in_ready;

    fhd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    fhd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign result_kind = out_data.result_kind;
    assign status      = out_data.status;
    assign frame_type  = out_data.frame_type;
    assign body_length = out_data.body_length;
    assign body_byte   = out_data.body_byte;
    assign last        = out_data.last;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the frame header deframer.
`timescale 1ns / 1ps

module testbench;
    import fhd_pkg::*;

    // The run is stopped here if it ever hangs. The limit leaves a wide margin
    // over the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;

    // A result is registered in the block's output stage when its byte is taken,
    // so these extra cycles are enough to see any beat that should not be there.
    localparam int DRAIN_CYCLES = 6;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic [7:0]             in_byte   = '0;
    logic                   out_ready = 1'b0;

    logic                   in_ready;
    logic                   out_valid;
    logic                   result_kind;
    logic [1:0]             status;
    logic [15:0]            frame_type;
    logic [31:0]            body_length;
    logic [7:0]             body_byte;
    logic                   last;

    // Our own copy of the configuration registers.
    logic [31:0] want_magic     = 32'd0;
    logic [15:0] want_version   = 16'd0;
    logic [31:0] length_ceiling = MAX_BODY_LENGTH_RESET;

    // Our own copy of the parser state.
    logic        in_frame_body = 1'b0;
    logic [3:0]  hdr_count     = '0;
    logic [31:0] magic_acc     = '0;
    logic [15:0] version_acc   = '0;
    logic [15:0] type_acc      = '0;
    logic [31:0] length_acc    = '0;
    logic [31:0] body_left     = '0;

    // Result beats predicted but not yet seen on the output, oldest first.
    result_t expected_results[$];

    int error_count       = 0;
    int cycle_count       = 0;
    int bytes_sent        = 0;
    int sender_idle_pct   = 23;
    int receiver_idle_pct = 72;
    int hold_request      = 0;
    int hold_left         = 0;

    frame_header_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .status      (status),
        .frame_type  (frame_type),
        .body_length (body_length),
        .body_byte   (body_byte),
        .last        (last)
    );

    always #10 clk = ~clk;

    // Watchdog: a hang anywhere in the run ends up here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Feeds one accepted byte through the predictor. Header bytes are shifted
    // into their fields; the last header byte gives the verdict, and in the
    // body every byte is passed through with the header fields repeated.
    task automatic deframe_byte(input logic [7:0] value);
        result_t beat;
        logic    frame_done;
        beat = '0;
        beat.frame_type  = type_acc;
        beat.body_length = length_acc;
        if (in_frame_body)
        begin
            frame_done       = (body_left <= 32'd1);
            beat.result_kind = KIND_BODY;
            beat.status      = STATUS_OK;
            beat.body_byte   = value;
            beat.last        = frame_done;
            expected_results.push_back(beat);
            if (frame_done)
            begin
                in_frame_body = 1'b0;
                body_left     = '0;
                hdr_count     = '0;
            end
            else
            begin
                body_left = body_left - 32'd1;
            end
        end
        else
        begin
            if (hdr_count < VERSION_START)
                magic_acc = {magic_acc[23:0], value};
            else if (hdr_count < TYPE_START)
                version_acc = {version_acc[7:0], value};
            else if (hdr_count < LENGTH_START)
                type_acc = {type_acc[7:0], value};
            else
                length_acc = {length_acc[23:0], value};

            if (hdr_count < LAST_HEADER)
            begin
                hdr_count = hdr_count + 4'd1;
            end
            else
            begin
                // The identity check wins over the length check.
                hdr_count        = '0;
                beat.frame_type  = type_acc;
                beat.body_length = length_acc;
                beat.result_kind = KIND_HEADER;
                if (magic_acc != want_magic || version_acc != want_version)
                    beat.status = STATUS_BAD_ID;
                else if (length_acc > length_ceiling)
                    beat.status = STATUS_TOO_LONG;
                else
                    beat.status = STATUS_OK;
                // A failed header and an empty body both close the frame at once.
                beat.last = (beat.status != STATUS_OK) || (length_acc == 32'd0);
                expected_results.push_back(beat);
                if (!beat.last)
                begin
                    in_frame_body = 1'b1;
                    body_left     = length_acc;
                end
            end
        end
    endtask

    // Offers one byte and waits for the beat to be taken. The payload only
    // changes at a falling edge, and valid stays up across back-to-back bytes
    // unless a random gap is drawn first.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        deframe_byte(value);
        bytes_sent++;
    endtask

    // Sends a whole frame: the big-endian header, then as many random body
    // bytes as the predictor says the accepted header asks for.
    task automatic send_frame(input logic [31:0] magic, input logic [15:0] version,
                              input logic [15:0] ftype, input logic [31:0] length);
        logic [95:0] header;
        header = {magic, version, ftype, length};
        for (int i = 0; i < HEADER_BYTES; i++)
            send_byte(header[95 - 8 * i -: 8]);
        while (in_frame_body)
            send_byte(8'($urandom));
    endtask

    // Lowers valid and lets every outstanding result beat come out, then
    // waits out the drain cycles so that nothing is left in flight.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles. Only called while
    // the stream is idle, so the new values apply to the next header.
    task automatic write_config(input logic [31:0] magic, input logic [15:0] version,
                                input logic [31:0] max_len);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_EXPECTED_MAGIC;
        cfg_data  <= magic;
        @(negedge clk);
        cfg_index <= CFG_EXPECTED_VERSION;
        cfg_data  <= CFG_DATA_W'(version);
        @(negedge clk);
        cfg_index <= CFG_MAX_BODY_LENGTH;
        cfg_data  <= max_len;
        @(negedge clk);
        cfg_write <= 1'b0;
        want_magic     = magic;
        want_version   = version;
        length_ceiling = max_len;
    endtask

    // One random frame. Most are well formed with short bodies so that the
    // body path is exercised; the rest break the identity check, break the
    // length check, or are plain noise whose first byte already spoils the
    // magic, so the stream always stays on a 12-byte boundary.
    task automatic send_random_frame();
        int          pick;
        logic [31:0] body_cap;
        logic [31:0] span;
        logic [31:0] len;
        logic [15:0] ftype;
        pick  = $urandom_range(99);
        ftype = 16'($urandom);
        body_cap = ($urandom_range(19) == 0) ? 32'd40 : 32'd12;
        if (length_ceiling < body_cap)
            body_cap = length_ceiling;
        if (pick < 55 || (pick >= 75 && pick < 85 && length_ceiling == 32'hFFFF_FFFF))
        begin
            len = $urandom_range(body_cap, 0);
            send_frame(want_magic, want_version, ftype, len);
        end
        else if (pick < 65)
        begin
            send_frame(want_magic ^ (32'd1 << $urandom_range(31)), want_version,
                       ftype, $urandom);
        end
        else if (pick < 75)
        begin
            send_frame(want_magic, want_version ^ (16'd1 << $urandom_range(15)),
                       ftype, $urandom);
        end
        else if (pick < 85)
        begin
            span = 32'hFFFF_FFFF - length_ceiling;
            case ($urandom_range(2))
                0:       len = length_ceiling + 32'd1;
                1:       len = 32'hFFFF_FFFF;
                default: len = length_ceiling + 32'd1 + ($urandom % span);
            endcase
            send_frame(want_magic, want_version, ftype, len);
        end
        else
        begin
            send_frame({want_magic[31:24] ^ 8'($urandom_range(255, 1)), 24'($urandom)},
                       16'($urandom), ftype, $urandom);
        end
    endtask

    // Reset values of the registers: magic 0, version 0, 64 KiB ceiling.
    task automatic test_reset_defaults();
        send_frame(32'd0, 16'd0, 16'h1234, 32'd2);
        send_frame(32'd0, 16'd0, 16'h0000, MAX_BODY_LENGTH_RESET + 32'd1);
        send_frame(32'd0, 16'h0001, 16'hFFFF, 32'd3);
        wait_drained();
    endtask

    // Each way a header can fail, the check order, and the length boundary.
    task automatic test_header_checks();
        write_config(32'hC0DE_F00D, 16'h0102, 32'd8);
        send_frame(32'hC0DE_F00C, 16'h0102, 16'hA001, 32'd4);
        send_frame(32'h40DE_F00D, 16'h0102, 16'hA002, 32'd4);
        send_frame(32'hC0DE_F00D, 16'h0103, 16'hA003, 32'd4);
        // Wrong magic together with an oversized length still reports the
        // identity failure.
        send_frame(32'h0000_0000, 16'h0102, 16'hA004, 32'hFFFF_FFFF);
        send_frame(32'hC0DE_F00D, 16'h0102, 16'hA005, 32'd9);
        send_frame(32'hC0DE_F00D, 16'h0102, 16'hA006, 32'd8);
        send_frame(32'hC0DE_F00D, 16'h0102, 16'hA007, 32'd0);
        send_frame(32'hC0DE_F00D, 16'h0102, 16'hA008, 32'd1);
        wait_drained();
    endtask

    // All-ones and all-zero register settings, with the extreme field values.
    task automatic test_config_extremes();
        write_config(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd3);
        send_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 32'd0);
        send_frame(32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF, 32'd5);
        wait_drained();
        write_config(32'd0, 16'd0, 32'd0);
        send_frame(32'd0, 16'd0, 16'h0000, 32'd0);
        send_frame(32'd0, 16'd0, 16'hFFFF, 32'd1);
        send_frame(32'd0, 16'd0, 16'h5A5A, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // The receiver stops for a long stretch while a long body keeps coming,
    // so the output stage and its skid entry fill and input ready must drop.
    task automatic test_backpressure();
        write_config(32'h1357_9BDF, 16'h00AA, 32'd64);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_request      = 80;
        send_frame(32'h1357_9BDF, 16'h00AA, 16'h0C0C, 32'd40);
        wait_drained();
    endtask

    // Random traffic under one register setting and one idling mix. Now and
    // then the sender pauses until every expected beat has come out.
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input logic [31:0] magic,
                                       input logic [15:0] version,
                                       input logic [31:0] max_len, input int byte_goal);
        int first_byte;
        wait_drained();
        write_config(magic, version, max_len);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        first_byte        = bytes_sent;
        while (bytes_sent - first_byte < byte_goal)
        begin
            send_random_frame();
            if ($urandom_range(19) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Receiver side: out_ready changes only at the falling edge. A long
    // hold-off requested by a test is counted down here, cycle by cycle.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            error_count++;
        end
    endtask

    // Every result beat taken at a rising edge is matched against the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin : check_beat
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual kind %0d",
                         $time, result_kind);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("result_kind", 32'(want.result_kind), 32'(result_kind));
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("frame_type", 32'(want.frame_type), 32'(frame_type));
                compare_field("body_length", want.body_length, body_length);
                compare_field("body_byte", 32'(want.body_byte), 32'(body_byte));
                compare_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_header_checks();
        test_config_extremes();
        test_backpressure();
        test_random_traffic(23, 72, $urandom, 16'($urandom), 32'd16, 140);
        test_random_traffic(72, 23, $urandom, 16'hFFFF, 32'hFFFF_FFFF, 140);
        test_random_traffic(0, 0, 32'd0, 16'd0, 32'd20, 140);

        wait_drained();
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected result beats never arrived",
                     $time, expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
